// ===== rtl/core/srs_pkg.sv =====
// ----------------------------------------------------------------------------
// srs_pkg: shared definitions for the stepper ramp sequencer
// Widths, register codes, item codes and the divider interface types.
// ----------------------------------------------------------------------------
package srs_pkg;

   localparam int DELAY_BITS = 16;
   localparam int COUNT_BITS = 24;

   // ramp index, divisor 4n+1, carried remainder, dividend 2*delay+rest
   localparam int IDX_W  = COUNT_BITS + 1;
   localparam int DIV_W  = COUNT_BITS + 3;
   localparam int REST_W = COUNT_BITS + 4;
   localparam int NUM_W  = ((DELAY_BITS + 2 > REST_W) ? DELAY_BITS + 2 : REST_W) + 1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = (DELAY_BITS > IDX_W) ? DELAY_BITS : IDX_W;

   localparam int REQ_DATA_W  = 8;
   localparam int REQ_USER_W  = 1;
   localparam int RSP_FIELD_W = DELAY_BITS + 3;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam int RSP_PULSE_BIT   = DELAY_BITS;
   localparam int RSP_RUNNING_BIT = DELAY_BITS + 1;
   localparam int RSP_LIMIT_BIT   = DELAY_BITS + 2;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FAST_PERIOD   = 3'd0,
      CSR_FIRST_DELAY   = 3'd1,
      CSR_BRAKE_STEP    = 3'd2,
      CSR_BRAKE_INDEX   = 3'd3,
      CSR_SINGLE_STEP   = 3'd4,
      CSR_LIMIT_STOP_EN = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic                    start;
      logic signed [NUM_W-1:0] num;
      logic signed [DIV_W-1:0] den;
   } srs_div_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [NUM_W-1:0]  quot;
      logic signed [REST_W-1:0] rest;
   } srs_div_rsp_type;

endpackage

// ===== rtl/core/stepper_linear_ramp_sequencer.sv =====
// ----------------------------------------------------------------------------
// stepper_linear_ramp_sequencer: per-step linear speed ramp sequencer
// Start and step transactions in, one step period transaction out for each.
// ----------------------------------------------------------------------------
// A start transaction (tuser 0) loads the first period and enters ACCEL, RUN
// or DECEL; each step transaction (tuser 1) returns the period for this step
// and advances the ramp. Start, RUN and STOP transactions go from acceptance
// through the PUBLISH state into the output register. ACCEL and DECEL
// transactions first wait in the DIV state for the serial divider that forms
// (2*delay + rest) / (4n + 1) one quotient bit per cycle, then go through
// PUBLISH. req_tready is high only while no transaction is in work; a
// finished result waits in the output register without blocking the next
// request. Configuration writes are always taken.
module stepper_linear_ramp_sequencer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [0] limit_hit
   input  logic [srs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] kind
   input  logic [srs_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [15:0] step_period, [16] pulse_enable, [17] running, [18] limit_stopped
   output logic [srs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [srs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [srs_pkg::CSR_DATA_W-1:0]   csr_data
);
   import srs_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_PUBLISH} state_type;
   typedef enum logic [1:0] {PH_STOP, PH_ACCEL, PH_RUN, PH_DECEL} phase_type;

   localparam logic signed [IDX_W-1:0] IDX_MAX = {1'b0, {COUNT_BITS{1'b1}}};
   localparam logic [DELAY_BITS-1:0]   DELAY_MAX = '1;

   state_type                state_ff;
   phase_type                phase_ff;
   logic [DELAY_BITS-1:0]    cur_ff;
   logic [DELAY_BITS-1:0]    last_ff;
   logic [COUNT_BITS-1:0]    steps_ff;
   logic signed [IDX_W-1:0]  idx_ff;
   logic signed [REST_W-1:0] rest_ff;
   logic                     latch_ff;

   logic [DELAY_BITS-1:0]    fast_period_ff;
   logic [DELAY_BITS-1:0]    first_delay_ff;
   logic [COUNT_BITS-1:0]    brake_step_ff;
   logic signed [IDX_W-1:0]  brake_index_ff;
   logic                     single_step_ff;
   logic                     limit_en_ff;

   logic [DELAY_BITS-1:0]    pend_period_ff;
   logic                     pend_pulse_ff;
   logic                     pend_run_ff;
   logic                     pend_limit_ff;
   logic                     rsp_valid_ff;
   logic [RSP_DATA_W-1:0]    rsp_data_ff;

   logic                     accept;
   logic                     is_start;
   logic                     latch_in;
   phase_type                phase_eff;
   logic [COUNT_BITS-1:0]    steps_inc;
   logic signed [IDX_W-1:0]  idx_inc;
   logic signed [NUM_W:0]    nd_wide;
   logic [DELAY_BITS-1:0]    nd_sat;
   srs_div_req_type          div_req;
   srs_div_rsp_type          div_rsp;

   srs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      is_start  = (req_tuser[0] == KIND_START);
      latch_in  = latch_ff | (limit_en_ff & req_tdata[0] & (phase_ff != PH_STOP));
      phase_eff = latch_in ? PH_STOP : phase_ff;
      steps_inc = (steps_ff == '1) ? steps_ff : steps_ff + 1'b1;
      idx_inc   = (idx_ff == IDX_MAX) ? idx_ff : idx_ff + IDX_W'(1);

      div_req.start = accept & ~is_start &
                      ((phase_eff == PH_ACCEL) || (phase_eff == PH_DECEL));
      div_req.num   = NUM_W'($signed({2'b00, cur_ff, 1'b0})) + NUM_W'(rest_ff);
      div_req.den   = {idx_inc, 2'b01};

      nd_wide = (NUM_W + 1)'($signed({1'b0, cur_ff})) - (NUM_W + 1)'(div_rsp.quot);
      if (nd_wide[NUM_W]) begin
         nd_sat = '0;
      end else if (|nd_wide[NUM_W-1:DELAY_BITS]) begin
         nd_sat = DELAY_MAX;
      end else begin
         nd_sat = nd_wide[DELAY_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_period_ff <= DELAY_BITS'(1);
         first_delay_ff <= DELAY_BITS'(1000);
         brake_step_ff  <= '0;
         brake_index_ff <= '1;
         single_step_ff <= 1'b0;
         limit_en_ff    <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_reg_type'(csr_index))
            CSR_FAST_PERIOD:   fast_period_ff <= csr_data[DELAY_BITS-1:0];
            CSR_FIRST_DELAY:   first_delay_ff <= csr_data[DELAY_BITS-1:0];
            CSR_BRAKE_STEP:    brake_step_ff  <= csr_data[COUNT_BITS-1:0];
            CSR_BRAKE_INDEX:   brake_index_ff <= $signed(csr_data[IDX_W-1:0]);
            CSR_SINGLE_STEP:   single_step_ff <= csr_data[0];
            CSR_LIMIT_STOP_EN: limit_en_ff    <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_STOP;
         cur_ff       <= '0;
         last_ff      <= '0;
         steps_ff     <= '0;
         idx_ff       <= '0;
         rest_ff      <= '0;
         latch_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_PUBLISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && is_start) begin
                  steps_ff      <= '0;
                  rest_ff       <= '0;
                  latch_ff      <= 1'b0;
                  pend_pulse_ff <= 1'b0;
                  pend_run_ff   <= 1'b1;
                  pend_limit_ff <= 1'b0;
                  state_ff      <= ST_PUBLISH;
                  if (single_step_ff) begin
                     idx_ff         <= '1;
                     phase_ff       <= PH_DECEL;
                     cur_ff         <= first_delay_ff;
                     pend_period_ff <= first_delay_ff;
                  end else if (first_delay_ff <= fast_period_ff) begin
                     idx_ff         <= '0;
                     phase_ff       <= PH_RUN;
                     cur_ff         <= fast_period_ff;
                     last_ff        <= fast_period_ff;
                     pend_period_ff <= fast_period_ff;
                  end else begin
                     idx_ff         <= '0;
                     phase_ff       <= PH_ACCEL;
                     cur_ff         <= first_delay_ff;
                     pend_period_ff <= first_delay_ff;
                  end
               end else if (accept) begin
                  latch_ff       <= latch_in;
                  pend_period_ff <= cur_ff;
                  pend_limit_ff  <= latch_in;
                  pend_pulse_ff  <= (phase_eff != PH_STOP);
                  pend_run_ff    <= (phase_eff != PH_STOP);
                  unique case (phase_eff)
                     PH_STOP: begin
                        phase_ff <= PH_STOP;
                        steps_ff <= '0;
                        rest_ff  <= '0;
                        state_ff <= ST_PUBLISH;
                     end
                     PH_RUN: begin
                        steps_ff <= steps_inc;
                        state_ff <= ST_PUBLISH;
                        if (steps_inc >= brake_step_ff) begin
                           idx_ff   <= brake_index_ff;
                           cur_ff   <= last_ff;
                           phase_ff <= PH_DECEL;
                        end else begin
                           cur_ff <= fast_period_ff;
                        end
                     end
                     PH_ACCEL, PH_DECEL: begin
                        steps_ff <= steps_inc;
                        idx_ff   <= idx_inc;
                        state_ff <= ST_DIV;
                     end
                  endcase
               end
            end
            ST_DIV: begin
               if (div_rsp.done) begin
                  state_ff <= ST_PUBLISH;
                  if ((phase_ff == PH_ACCEL) && (steps_ff >= brake_step_ff)) begin
                     rest_ff  <= div_rsp.rest;
                     cur_ff   <= nd_sat;
                     idx_ff   <= brake_index_ff;
                     phase_ff <= PH_DECEL;
                  end else if ((phase_ff == PH_ACCEL) && (nd_sat <= fast_period_ff)) begin
                     last_ff  <= nd_sat;
                     cur_ff   <= fast_period_ff;
                     rest_ff  <= '0;
                     phase_ff <= PH_RUN;
                  end else begin
                     rest_ff <= div_rsp.rest;
                     cur_ff  <= nd_sat;
                     if ((phase_ff == PH_DECEL) && !idx_ff[IDX_W-1]) begin
                        phase_ff <= PH_STOP;
                     end
                  end
               end
            end
            ST_PUBLISH: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= RSP_DATA_W'({pend_limit_ff, pend_run_ff,
                                               pend_pulse_ff, pend_period_ff});
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/core/srs_div.sv =====
// ----------------------------------------------------------------------------
// srs_div: serial signed divider
// Restoring divider, one quotient bit per cycle on magnitudes, then a sign
// fix-up step. Quotient truncates toward zero; remainder takes the
// dividend's sign.
// ----------------------------------------------------------------------------
module srs_div (
   input  logic                    clock,
   input  logic                    reset,
   input  srs_pkg::srs_div_req_type div_req,
   output srs_pkg::srs_div_rsp_type div_rsp
);
   import srs_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [CNT_W-1:0]         cnt_ff;
   logic                     fix_ff;
   logic                     done_ff;
   logic                     num_neg_ff;
   logic                     quo_neg_ff;
   logic [DIV_W-1:0]         den_mag_ff;
   logic [DIV_W-1:0]         part_ff;
   logic [NUM_W-1:0]         quo_ff;
   logic signed [NUM_W-1:0]  quot_ff;
   logic signed [REST_W-1:0] rest_ff;

   logic [NUM_W-1:0]  num_mag;
   logic [DIV_W-1:0]  den_mag;
   logic [DIV_W:0]    trial;
   logic [DIV_W:0]    trial_sub;
   logic              fits;
   logic [DIV_W-1:0]  part_in;
   logic [REST_W-1:0] rem_pos;

   always_comb begin
      num_mag   = div_req.num[NUM_W-1] ? NUM_W'(-div_req.num) : NUM_W'(div_req.num);
      den_mag   = div_req.den[DIV_W-1] ? DIV_W'(-div_req.den) : DIV_W'(div_req.den);
      trial     = {part_ff, quo_ff[NUM_W-1]};
      trial_sub = trial - {1'b0, den_mag_ff};
      fits      = (trial >= {1'b0, den_mag_ff});
      part_in   = fits ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
      rem_pos   = {{(REST_W - DIV_W){1'b0}}, part_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         fix_ff  <= 1'b0;
         if (div_req.start) begin
            cnt_ff <= CNT_W'(NUM_W);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
            fix_ff <= (cnt_ff == CNT_W'(1));
         end
         if (fix_ff) begin
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         num_neg_ff <= div_req.num[NUM_W-1];
         quo_neg_ff <= div_req.num[NUM_W-1] ^ div_req.den[DIV_W-1];
         den_mag_ff <= den_mag;
         part_ff    <= '0;
         quo_ff     <= num_mag;
      end else if (cnt_ff != '0) begin
         part_ff <= part_in;
         quo_ff  <= {quo_ff[NUM_W-2:0], fits};
      end
      if (fix_ff) begin
         quot_ff <= quo_neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
         rest_ff <= num_neg_ff ? -$signed(rem_pos) : $signed(rem_pos);
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
   assign div_rsp.rest = rest_ff;

endmodule

// ===== rtl/core/srs_checker.sv =====
// ----------------------------------------------------------------------------
// srs_checker: port-level checks for the stepper ramp sequencer
// Watches the request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module srs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [srs_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import srs_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a transaction is in work");

   a_pulse_running: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_PULSE_BIT] |-> rsp_tdata[RSP_RUNNING_BIT])
      else $error("step pulse without a move in progress");

   a_limit_stopped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_LIMIT_BIT] |->
         !rsp_tdata[RSP_RUNNING_BIT] && !rsp_tdata[RSP_PULSE_BIT])
      else $error("limit stop reported while still moving");

   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

endmodule

bind stepper_linear_ramp_sequencer srs_checker u_srs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
